// ===== hw/rtl/boxds_pkg.sv =====
`default_nettype none

package boxds_pkg;

    // Default frame geometry
    localparam int SRC_SIZE_DEF = 64;
    localparam int DST_SIZE_DEF = 28;

    // Q1.15 result format
    localparam int          QUO_W = 16;
    localparam logic [15:0] Q_ONE = 16'h8000;

    // Configuration register indexes
    localparam int          CFG_IDX_W  = 2;
    localparam logic [1:0]  CFG_INVERT = 2'd0;
    localparam logic [1:0]  CFG_BLANK  = 2'd1;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  dst_row;
        logic [4:0]  dst_col;
        logic [15:0] value;
        logic        frame_last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/boxds_ram.sv =====
`default_nettype none

module boxds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 28,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/box_average_image_downscaler_core.sv =====
`default_nettype none

// Box-average downscaler: takes the pixels of a SRC_SIZE x SRC_SIZE frame in
// raster order and emits one Q1.15 result per DST_SIZE x DST_SIZE output cell,
// the cell mean scaled to 1.0 = 32768 (optionally inverted, with destination
// row zero optionally forced to zero). Per-cell sums and counts for one output
// row sit in a small RAM with valid bits, so frame_start clears them at once.
// A pixel that finishes no cell is accepted, then its cell accumulator gets a
// read-modify-write. A pixel that finishes a cell passes through the accept
// state, the accumulate state, a state that forms the divisor count*255, the
// bit-serial restoring divider that produces the 16-bit quotient, and the
// state that loads the output register. Input stall is high
// while an item is in work. A finished result waits in the output register
// while further pixels are accepted; the block holds only if a second result
// is ready before the first is taken. Configuration writes are always ready.
module box_average_image_downscaler_core #(
    parameter int SRC_SIZE = boxds_pkg::SRC_SIZE_DEF,
    parameter int DST_SIZE = boxds_pkg::DST_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire boxds_pkg::t_in_item            i_data,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output boxds_pkg::t_out_item                o_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [boxds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                           i_cfg_data
);

    import boxds_pkg::*;

    localparam int SRC_W  = $clog2(SRC_SIZE);
    localparam int DST_W  = (DST_SIZE > 1) ? $clog2(DST_SIZE) : 1;
    localparam int CELL_N = ((SRC_SIZE + DST_SIZE - 1) / DST_SIZE) ** 2;
    localparam int CNT_W  = $clog2(CELL_N + 1);
    localparam int SUM_W  = CNT_W + 8;
    localparam int DIV_W  = CNT_W + 8;
    localparam int MEM_W  = CNT_W + SUM_W;
    localparam int STEP_W = $clog2(QUO_W);

    localparam logic [SRC_W:0]    SRC_V    = (SRC_W + 1)'(SRC_SIZE);
    localparam logic [SRC_W-1:0]  SRC_LAST = SRC_W'(SRC_SIZE - 1);
    localparam logic [SRC_W:0]    DR_V     = (SRC_W + 1)'(DST_SIZE % SRC_SIZE);
    localparam logic [DST_W-1:0]  DQ_V     = DST_W'(DST_SIZE / SRC_SIZE);
    localparam logic [DST_W-1:0]  DST_LAST = DST_W'(DST_SIZE - 1);
    localparam logic [STEP_W-1:0] STEP_END = STEP_W'(QUO_W - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]          r_state;
    logic                r_invert;
    logic                r_blank;

    // Source position and its mapping onto the output grid
    logic [SRC_W-1:0]    r_col, r_row;
    logic [SRC_W-1:0]    r_col_rem, r_row_rem;
    logic [DST_W-1:0]    r_dc_pos, r_dr_pos;
    logic [SRC_W-1:0]    n_col, n_row, n_col_rem, n_row_rem;
    logic [DST_W-1:0]    n_dc_pos, n_dr_pos;

    // Item in work
    logic [7:0]          r_pix;
    logic [DST_W-1:0]    r_dc, r_dr;
    logic                r_emit;
    logic                r_last;
    logic [DST_SIZE-1:0] r_valid;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;

    // Divider
    logic [DIV_W-1:0]    r_div;
    logic [DIV_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;

    // Output register
    logic                r_o_valid;
    t_out_item           r_out;

    logic                accept;
    logic                fs;
    logic [SRC_W-1:0]    c_eff, r_eff, c_rem_eff, r_rem_eff;
    logic [DST_W-1:0]    dc_eff, dr_eff;
    logic [SRC_W:0]      t_c, t_r;
    logic                c_carry, r_carry, c_end, r_end, last_c, last_r;
    logic [MEM_W-1:0]    mem_rdata;
    logic [SUM_W-1:0]    old_sum, sum_new;
    logic [CNT_W-1:0]    old_cnt, cnt_new;
    logic [DIV_W:0]      sh;
    logic [DIV_W:0]      diff;
    logic                ge;
    logic                out_load;
    logic [QUO_W-1:0]    value;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign fs          = i_data.frame_start;

    // Position of this pixel; frame start restarts at the origin
    assign c_eff     = fs ? '0 : r_col;
    assign r_eff     = fs ? '0 : r_row;
    assign c_rem_eff = fs ? '0 : r_col_rem;
    assign r_rem_eff = fs ? '0 : r_row_rem;
    assign dc_eff    = fs ? '0 : r_dc_pos;
    assign dr_eff    = fs ? '0 : r_dr_pos;

    // Step the grid mapping: position*DST = cell*SRC + remainder
    assign t_c     = {1'b0, c_rem_eff} + DR_V;
    assign t_r     = {1'b0, r_rem_eff} + DR_V;
    assign c_carry = (t_c >= SRC_V);
    assign r_carry = (t_r >= SRC_V);
    assign c_end   = (c_eff == SRC_LAST);
    assign r_end   = (r_eff == SRC_LAST);
    assign last_c  = c_end || (DQ_V != '0) || c_carry;
    assign last_r  = r_end || (DQ_V != '0) || r_carry;

    always_comb begin
        n_col     = c_eff + SRC_W'(1);
        n_col_rem = c_carry ? SRC_W'(t_c - SRC_V) : SRC_W'(t_c);
        n_dc_pos  = dc_eff + DQ_V + DST_W'(c_carry);
        n_row     = r_eff;
        n_row_rem = r_rem_eff;
        n_dr_pos  = dr_eff;
        if (c_end) begin
            n_col     = '0;
            n_col_rem = '0;
            n_dc_pos  = '0;
            n_row     = r_eff + SRC_W'(1);
            n_row_rem = r_carry ? SRC_W'(t_r - SRC_V) : SRC_W'(t_r);
            n_dr_pos  = dr_eff + DQ_V + DST_W'(r_carry);
            if (r_end) begin
                n_row     = '0;
                n_row_rem = '0;
                n_dr_pos  = '0;
            end
        end
    end

    // Cell accumulators: {count, sum} per output column
    boxds_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DST_SIZE)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_ACC),
        .i_waddr (r_dc),
        .i_wdata ({cnt_new, sum_new}),
        .i_raddr (dc_eff),
        .o_rdata (mem_rdata)
    );

    assign old_sum = r_valid[r_dc] ? mem_rdata[SUM_W-1:0] : '0;
    assign old_cnt = r_valid[r_dc] ? mem_rdata[MEM_W-1:SUM_W] : '0;
    assign sum_new = old_sum + SUM_W'(r_pix);
    assign cnt_new = old_cnt + CNT_W'(1);

    // One restoring division step per cycle
    assign sh   = {r_rem, r_quo[QUO_W-1]};
    assign diff = sh - {1'b0, r_div};
    assign ge   = (sh >= {1'b0, r_div});

    // Final value from the quotient
    always_comb begin
        value = r_invert ? (Q_ONE - r_quo) : r_quo;
        if (r_blank && (r_dr == '0)) begin
            value = '0;
        end
    end

    assign out_load = (r_state == ST_DONE) && (!r_o_valid || !i_stall);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b1;
            r_blank  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INVERT: r_invert <= i_cfg_data;
                CFG_BLANK:  r_blank  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer, position and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_col_rem <= '0;
            r_row_rem <= '0;
            r_dc_pos  <= '0;
            r_dr_pos  <= '0;
            r_valid   <= '0;
            r_step    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_col     <= n_col;
                        r_row     <= n_row;
                        r_col_rem <= n_col_rem;
                        r_row_rem <= n_row_rem;
                        r_dc_pos  <= n_dc_pos;
                        r_dr_pos  <= n_dr_pos;
                        if (fs) begin
                            r_valid <= '0;
                        end
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_valid[r_dc] <= !r_emit;
                    r_state       <= r_emit ? ST_PREP : ST_IDLE;
                end
                ST_PREP: begin
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_END) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Request payload and divider datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_data.pixel;
            r_dc   <= dc_eff;
            r_dr   <= dr_eff;
            r_emit <= last_r && last_c;
            r_last <= (dr_eff == DST_LAST) && (dc_eff == DST_LAST);
        end
        if (r_state == ST_ACC) begin
            r_sum <= sum_new;
            r_cnt <= cnt_new;
        end
        if (r_state == ST_PREP) begin
            r_div <= {r_cnt, 8'h00} - DIV_W'(r_cnt);
            r_rem <= DIV_W'(r_sum >> 1);
            r_quo <= {r_sum[0], {(QUO_W - 1){1'b0}}};
        end
        if (r_state == ST_DIV) begin
            r_rem <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
        if (out_load) begin
            r_out.dst_row    <= 5'(r_dr);
            r_out.dst_col    <= 5'(r_dc);
            r_out.value      <= value;
            r_out.frame_last <= r_last;
        end
    end

    // Output register: load from the divider, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_quo <= Q_ONE))
        else $error("cell mean above 1.0");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && (r_state == ST_IDLE)))
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import boxds_pkg::*;

    localparam int SRC = SRC_SIZE_DEF;
    localparam int DST = DST_SIZE_DEF;
    // Settling wait that lets a cell-closing pixel finish in the block
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {FILL_RANDOM, FILL_BLACK, FILL_WHITE, FILL_STRIPES} t_fill_style;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_item i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_item o_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic i_cfg_data = 1'b0;

    // Predicted state of the downscaler
    logic [11:0] cell_sum[DST];
    logic [3:0] cell_cnt[DST];
    int next_row;
    int next_col;
    logic invert_on;
    logic blank_on;

    t_out_item expected_cells[$];
    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    box_average_image_downscaler_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drive receiver stall: long hold-off first, else random
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cells.size() == 0) begin
                $error("unexpected result: row %0d col %0d value %0d last %0d",
                       o_data.dst_row, o_data.dst_col, o_data.value, o_data.frame_last);
                fail_count++;
            end else begin
                want = expected_cells.pop_front();
                if (o_data.dst_row !== want.dst_row) begin
                    $error("dst_row: expected %0d, got %0d", want.dst_row, o_data.dst_row);
                    fail_count++;
                end
                if (o_data.dst_col !== want.dst_col) begin
                    $error("dst_col: expected %0d, got %0d", want.dst_col, o_data.dst_col);
                    fail_count++;
                end
                if (o_data.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, o_data.value);
                    fail_count++;
                end
                if (o_data.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d",
                           want.frame_last, o_data.frame_last);
                    fail_count++;
                end
            end
        end
    end

    function automatic int cell_of(input int pos);
        return (pos * DST) / SRC;
    endfunction

    function automatic bit closes_cell(input int pos);
        return (pos + 1 >= SRC) || (cell_of(pos + 1) != cell_of(pos));
    endfunction

    function automatic logic [7:0] fill_pixel(input t_fill_style style, input int k);
        case (style)
            FILL_BLACK:   return 8'd0;
            FILL_WHITE:   return 8'd255;
            FILL_STRIPES: return (k % 2 == 0) ? 8'd255 : 8'd0;
            default:      return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic clear_cells();
        foreach (cell_sum[k]) begin
            cell_sum[k] = '0;
            cell_cnt[k] = '0;
        end
    endtask

    // Accumulate one accepted pixel and queue the cell it closes, if any
    task automatic accumulate_pixel(input logic [7:0] pix, input logic fs);
        int r;
        int c;
        int dr;
        int dc;
        longint mean;
        t_out_item item;
        if (fs) begin
            next_row = 0;
            next_col = 0;
            clear_cells();
        end
        r = next_row;
        c = next_col;
        dr = cell_of(r);
        dc = cell_of(c);
        cell_sum[dc] = cell_sum[dc] + pix;
        cell_cnt[dc] = cell_cnt[dc] + 1'b1;
        if (closes_cell(r) && closes_cell(c)) begin
            mean = (longint'(cell_sum[dc]) << 15) / (longint'(cell_cnt[dc]) * 255);
            if (mean > longint'(Q_ONE))
                mean = longint'(Q_ONE);
            item.dst_row = 5'(dr);
            item.dst_col = 5'(dc);
            item.value = invert_on ? 16'(longint'(Q_ONE) - mean) : 16'(mean);
            if (blank_on && dr == 0)
                item.value = '0;
            item.frame_last = (dr == DST - 1) && (dc == DST - 1);
            expected_cells.push_back(item);
            cell_sum[dc] = '0;
            cell_cnt[dc] = '0;
        end
        next_col = c + 1;
        if (next_col >= SRC) begin
            next_col = 0;
            next_row = (r + 1 >= SRC) ? 0 : r + 1;
        end
    endtask

    // Offer one pixel request, idling at random first, and hold until taken
    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data <= '{pixel: pix, frame_start: fs};
        do @(posedge i_clk); while (o_stall);
        accumulate_pixel(pix, fs);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (expected_cells.size() != 0)
            @(posedge i_clk);
    endtask

    // Let the block finish the last pixel in work as well
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_INVERT: invert_on = val;
            CFG_BLANK:  blank_on = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic inv, input logic blank);
        wait_idle();
        write_reg(CFG_INVERT, inv);
        write_reg(CFG_BLANK, blank);
    endtask

    // Field extremes and mid-frame restarts, default register settings
    task automatic test_directed_edges();
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hFE, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'hC3, 1'b0);
        send_pixel(8'h3C, 1'b0);
        send_pixel(8'd255, 1'b1);
        drop_valid();
    endtask

    // Runs of raster pixels in a randomly chosen fill style, some broken by restarts
    task automatic test_random_frames(input int n_items);
        int sent;
        int len;
        logic fs;
        t_fill_style style;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) < 7) ? $urandom_range(130, 420) : $urandom_range(1, 60);
            style = t_fill_style'($urandom_range(3));
            for (int k = 0; k < len && sent < n_items; k++) begin
                if (k == 0)
                    fs = ($urandom_range(4) != 0);
                else
                    fs = ($urandom_range(99) == 0);
                send_pixel(fill_pixel(style, k), fs);
                sent++;
            end
        end
        drop_valid();
    endtask

    // Hold the receiver off while pixels keep coming so the block backs up
    task automatic test_output_backpressure();
        @(posedge i_clk);
        hold_left = 2000;
        for (int k = 0; k < 200; k++)
            send_pixel(8'($urandom_range(255)), k == 0);
        drop_valid();
    endtask

    // Pause mid-frame until every pending cell is out, then resume
    task automatic test_sender_pause();
        for (int k = 0; k < 150; k++)
            send_pixel(8'($urandom_range(255)), k == 0);
        drop_valid();
        wait_results();
        for (int k = 0; k < 60; k++)
            send_pixel(8'($urandom_range(255)), 1'b0);
        drop_valid();
    endtask

    // Rows of pattern or random fill, one style per row, from a frame start
    task automatic test_pattern_rows(input int n_items);
        t_fill_style style;
        style = FILL_RANDOM;
        for (int k = 0; k < n_items; k++) begin
            if (k % SRC == 0)
                style = t_fill_style'($urandom_range(3));
            send_pixel(fill_pixel(style, k), k == 0);
        end
        drop_valid();
    endtask

    initial begin
        next_row = 0;
        next_col = 0;
        invert_on = 1'b1;
        blank_on = 1'b1;
        clear_cells();

        // Hold reset, then release it on a falling clock edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_stall_pct = 70;
        test_directed_edges();
        set_mode(1'b0, 1'b0);
        test_random_frames(120);

        send_idle_pct = 70;
        recv_stall_pct = 14;
        set_mode(1'b1, 1'b0);
        test_random_frames(120);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_mode(1'b0, 1'b1);
        test_random_frames(120);
        test_sender_pause();

        // Spare indexes must not touch either register
        wait_idle();
        write_reg(CFG_SPARE_LO, 1'b0);
        write_reg(CFG_SPARE_HI, 1'b0);
        write_reg(CFG_INVERT, 1'b1);
        write_reg(CFG_BLANK, 1'b1);
        write_reg(CFG_SPARE_LO, 1'b1);
        write_reg(CFG_SPARE_HI, 1'b1);
        test_pattern_rows(140);

        wait_idle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/boxds_pkg.sv
hw/rtl/boxds_ram.sv
hw/rtl/box_average_image_downscaler_core.sv
tb/sv/testbench.sv
